>>> sv/dfd_pkg.sv
// shared constants, types and register codes of the duplicate frame detector
// no dependencies; every other file of the block but dfd_res_if imports this package
`default_nettype none

package dfd_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned PLANE_W     = 2;
  localparam int unsigned NUM_PLANES  = 3;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned CNT_W       = 25;
  localparam int unsigned LIMIT_W     = 9;
  localparam int unsigned THR_W       = 27;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 27;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned DEF_MAX_PLANE_PIXELS = 16777216;
  localparam int unsigned DEF_FRACTION_BITS    = 16;

  localparam logic [PIX_W-1:0] MISMATCH_VALUE = PIX_W'(255);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_ONLY   = 2'd2;

  typedef struct packed {
    logic [LIMIT_W-1:0]      match_limit;
    logic signed [THR_W-1:0] frame_thr;
    logic                    luma_only;
  } cfg_t;

  // per-plane sums and pixel counts of one finished frame
  typedef struct packed {
    logic [NUM_PLANES-1:0][SUM_W-1:0] sum_cur;
    logic [NUM_PLANES-1:0][SUM_W-1:0] sum_prv;
    logic [NUM_PLANES-1:0][SUM_W-1:0] sum_nxt;
    logic [NUM_PLANES-1:0][CNT_W-1:0] cnt;
  } frame_sums_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

>>> sv/dfd_pix_if.sv
// pixel channel of the duplicate frame detector: valid/ready plus pixel payload
// depends on dfd_pkg for field widths
`default_nettype none

interface dfd_pix_if import dfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   cur_pixel;
  logic [PIX_W-1:0]   prev_pixel;
  logic [PIX_W-1:0]   next_pixel;
  logic [PLANE_W-1:0] plane;
  logic               frame_end;

  modport source (output valid, cur_pixel, prev_pixel, next_pixel, plane, frame_end,
                  input ready);
  modport sink   (input valid, cur_pixel, prev_pixel, next_pixel, plane, frame_end,
                  output ready);
endinterface

`default_nettype wire

>>> sv/dfd_res_if.sv
// result channel of the duplicate frame detector: valid/ready plus decision bit
// no dependencies
`default_nettype none

interface dfd_res_if ();
  logic valid;
  logic ready;
  logic is_duplicate;

  modport source (output valid, is_duplicate, input ready);
  modport sink   (input valid, is_duplicate, output ready);
endinterface

`default_nettype wire

>>> sv/duplicate_frame_detector.sv
// duplicate frame detector top level: configuration registers, front end,
// frame queue and divide/decide back end; depends on dfd_pkg, dfd_pix_if,
// dfd_res_if, dfd_front, dfd_queue and dfd_back
//
// usage
// - pix_i carries one co-located pixel triple (current, previous, next frame)
//   with its plane index per transaction; frame_end marks the frame's last pixel
// - pixels are taken one per clock while pix_i.ready is high; only a transaction
//   with frame_end set produces a result, one is_duplicate bit on res_o
// - the front end adds each pixel into per-plane sums in the same cycle; at
//   frame end the sums move into a two-frame queue and the accumulators clear,
//   so the next frame streams in without a gap
// - the back end divides each of up to nine sums by its plane count with a
//   one-bit-per-cycle restoring divider, each divide after a load step; a frame
//   decision divides three sums instead of nine in luma-only mode
// - pix_i.ready drops only while two finished frames wait in the queue
// - res_o holds its result until taken; a stalled receiver holds back the next
//   decision, not the pixel stream, until the queue fills
// - reset clears sums, counts, the queue and config; the user must write config
//   via cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle, which is not enforced
`default_nettype none

module duplicate_frame_detector import dfd_pkg::*; #(
  parameter int unsigned MAX_PLANE_PIXELS = DEF_MAX_PLANE_PIXELS,
  parameter int unsigned FRACTION_BITS    = DEF_FRACTION_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dfd_pix_if.sink                    pix_i,
  dfd_res_if.source                  res_o
);

  cfg_t          cfg_q, cfg_d;
  logic          push, pop;
  frame_sums_t   push_sums, head_sums;
  queue_status_t q_status;

  // register writes, unknown index is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MATCH_LIMIT: cfg_d.match_limit = cfg_wdata_i[LIMIT_W-1:0];
        CFG_FRAME_THR:   cfg_d.frame_thr   = signed'(cfg_wdata_i[THR_W-1:0]);
        CFG_LUMA_ONLY:   cfg_d.luma_only   = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // per-pixel accumulation
  dfd_front #(
    .MAX_PLANE_PIXELS (MAX_PLANE_PIXELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pix_i      (pix_i),
    .q_status_i (q_status),
    .push_o     (push),
    .sums_o     (push_sums)
  );

  // finished frames waiting for the divider
  dfd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_sums),
    .pop_i    (pop),
    .head_o   (head_sums),
    .status_o (q_status)
  );

  // averages, totals and the duplicate decision
  dfd_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head_sums),
    .q_status_i (q_status),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

>>> sv/dfd_front.sv
// front end: takes pixels, accumulates per-plane sums and counts, hands a frame off
// depends on dfd_pkg and dfd_pix_if
`default_nettype none

module dfd_front import dfd_pkg::*; #(
  parameter int unsigned MAX_PLANE_PIXELS = DEF_MAX_PLANE_PIXELS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  dfd_pix_if.sink            pix_i,
  input  wire queue_status_t q_status_i,
  output logic               push_o,
  output frame_sums_t        sums_o
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PLANE_PIXELS);

  frame_sums_t      acc_q, acc_d, upd;
  logic             pix_acc, pix_use;
  logic [PIX_W-1:0] diff_prv, diff_nxt, val_prv, val_nxt;

  assign pix_i.ready = ~q_status_i.full;
  assign pix_acc     = pix_i.valid & pix_i.ready;

  always_comb begin
    diff_prv = (pix_i.cur_pixel >= pix_i.prev_pixel) ? pix_i.cur_pixel - pix_i.prev_pixel
                                                     : pix_i.prev_pixel - pix_i.cur_pixel;
    diff_nxt = (pix_i.cur_pixel >= pix_i.next_pixel) ? pix_i.cur_pixel - pix_i.next_pixel
                                                     : pix_i.next_pixel - pix_i.cur_pixel;
    val_prv  = ({1'b0, diff_prv} < cfg_i.match_limit) ? pix_i.cur_pixel : MISMATCH_VALUE;
    val_nxt  = ({1'b0, diff_nxt} < cfg_i.match_limit) ? pix_i.cur_pixel : MISMATCH_VALUE;
  end

  // unused plane code and chroma in luma-only mode are dropped
  assign pix_use = pix_acc && (pix_i.plane < PLANE_W'(NUM_PLANES)) &&
                   (!cfg_i.luma_only || (pix_i.plane == '0));

  always_comb begin
    upd = acc_q;
    for (int i = 0; i < NUM_PLANES; i++) begin
      if (pix_use && (pix_i.plane == PLANE_W'(i)) && (acc_q.cnt[i] < CNT_MAX)) begin
        upd.sum_cur[i] = acc_q.sum_cur[i] + SUM_W'(pix_i.cur_pixel);
        upd.sum_prv[i] = acc_q.sum_prv[i] + SUM_W'(val_prv);
        upd.sum_nxt[i] = acc_q.sum_nxt[i] + SUM_W'(val_nxt);
        upd.cnt[i]     = acc_q.cnt[i] + CNT_W'(1);
      end
    end
  end

  assign push_o = pix_acc & pix_i.frame_end;
  assign sums_o = upd;
  assign acc_d  = push_o ? '0 : upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  a_clear_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (acc_q.cnt[0] == '0) && (acc_q.cnt[1] == '0) && (acc_q.cnt[2] == '0))
    else $error("accumulators not cleared after frame end");

endmodule

`default_nettype wire

>>> sv/dfd_queue.sv
// two-entry queue of finished frame sums between front end and back end
// depends on dfd_pkg
`default_nettype none

module dfd_queue import dfd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire frame_sums_t  entry_i,
  input  wire logic         pop_i,
  output frame_sums_t       head_o,
  output queue_status_t     status_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  frame_sums_t       ent_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= entry_i;
    end
  end

  assign head_o              = ent_q[rd_q];
  assign status_o.head_valid = (fill_q != '0);
  assign status_o.full       = (fill_q == FILL_W'(QUEUE_DEPTH));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (fill_q != FILL_W'(QUEUE_DEPTH)))
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (fill_q != '0))
    else $error("frame queue popped while empty");

endmodule

`default_nettype wire

>>> sv/dfd_back.sv
// back end: bit-serial division of each sum by its plane count, totals, decision
// depends on dfd_pkg and dfd_res_if
`default_nettype none

module dfd_back import dfd_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire frame_sums_t   head_i,
  input  wire queue_status_t q_status_i,
  output logic               pop_o,
  dfd_res_if.source          res_o
);

  localparam int unsigned DW     = SUM_W + FRACTION_BITS;
  localparam int unsigned TW     = DW + 3;
  localparam int unsigned STEP_W = $clog2(DW);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [1:0] KIND_CUR = 2'd0;
  localparam logic [1:0] KIND_PRV = 2'd1;
  localparam logic [1:0] KIND_NXT = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [PLANE_W-1:0]  plane_q, plane_d;
  logic [1:0]          kind_q, kind_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [DW-1:0]       quo_q, quo_d;
  logic [CNT_W-1:0]    rem_q, rem_d, den_q, den_d;
  logic signed [TW-1:0] tot_cur_q, tot_cur_d, tot_prv_q, tot_prv_d, tot_nxt_q, tot_nxt_d;
  logic                out_valid_q, out_valid_d, out_dup_q, out_dup_d;

  logic [SUM_W-1:0]     op_sum;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;
  logic [DW-1:0]        quo_res;
  logic signed [TW-1:0] avg, thr_ext, ref_total;
  logic                 last_div, dup;

  always_comb begin
    case (kind_q)
      KIND_CUR: op_sum = head_i.sum_cur[plane_q];
      KIND_PRV: op_sum = head_i.sum_prv[plane_q];
      default:  op_sum = head_i.sum_nxt[plane_q];
    endcase
  end

  // one restoring step per cycle, dividend shifts out of quo_q as quotient shifts in
  assign trial    = {rem_q, quo_q[DW-1]};
  assign trial_ge = (trial >= {1'b0, den_q});
  assign quo_res  = (den_q == '0) ? '0 : {quo_q[DW-2:0], trial_ge};
  assign avg      = signed'({{(TW - DW){1'b0}}, quo_res});

  assign last_div  = (kind_q == KIND_NXT) &&
                     ((plane_q == PLANE_W'(NUM_PLANES - 1)) || cfg_i.luma_only);
  assign thr_ext   = signed'({{(TW - THR_W){cfg_i.frame_thr[THR_W-1]}}, cfg_i.frame_thr});
  assign ref_total = tot_cur_q + thr_ext;
  assign dup       = (tot_prv_q < ref_total) && (tot_nxt_q > ref_total);

  always_comb begin
    state_d     = state_q;
    plane_d     = plane_q;
    kind_d      = kind_q;
    step_d      = step_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    tot_cur_d   = tot_cur_q;
    tot_prv_d   = tot_prv_q;
    tot_nxt_d   = tot_nxt_q;
    out_valid_d = out_valid_q & ~res_o.ready;
    out_dup_d   = out_dup_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_status_i.head_valid) begin
          plane_d   = '0;
          kind_d    = KIND_CUR;
          tot_cur_d = '0;
          tot_prv_d = '0;
          tot_nxt_d = '0;
          state_d   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        quo_d   = {op_sum, {FRACTION_BITS{1'b0}}};
        den_d   = head_i.cnt[plane_q];
        rem_d   = '0;
        step_d  = STEP_W'(DW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        quo_d = {quo_q[DW-2:0], trial_ge};
        rem_d = trial_ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
        if (step_q == '0) begin
          case (kind_q)
            KIND_CUR: tot_cur_d = tot_cur_q + avg;
            KIND_PRV: tot_prv_d = tot_prv_q + avg;
            default:  tot_nxt_d = tot_nxt_q + avg;
          endcase
          if (last_div) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_LOAD;
            if (kind_q == KIND_NXT) begin
              kind_d  = KIND_CUR;
              plane_d = plane_q + PLANE_W'(1);
            end else begin
              kind_d = kind_q + 2'd1;
            end
          end
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_dup_d   = dup;
          pop_o       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plane_q     <= '0;
      kind_q      <= KIND_CUR;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plane_q     <= plane_d;
      kind_q      <= kind_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    tot_cur_q <= tot_cur_d;
    tot_prv_q <= tot_prv_d;
    tot_nxt_q <= tot_nxt_d;
    out_dup_q <= out_dup_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.is_duplicate = out_dup_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((rem_q < den_q) || (den_q == '0)))
    else $error("division remainder reached the divisor");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the decision step");

endmodule

`default_nettype wire
